// ===== hw/rtl/sha_pkg.sv =====
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== hw/rtl/sha256_message_hasher_top.sv =====
// A byte request without last is absorbed while idle. A block-completing byte loads the
// 16 block words from the block RAM, runs the 64 rounds and then one chain update.
// A last request takes 64-f padding writes (f = bytes held), 8 length writes and a
// compression, with a second zero block when f >= 56, then 8 digest words at one per
// unstalled cycle; only one request is handled at a time, set by the single round unit.
// Reset (rst_n low, synchronous) restores the initial hash, clears counts and state.
module sha256_message_hasher_top import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_has_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPad   = 4'd1;
  localparam logic [3:0] StLen   = 4'd2;
  localparam logic [3:0] StLoad  = 4'd3;
  localparam logic [3:0] StRound = 4'd4;
  localparam logic [3:0] StFold  = 4'd5;
  localparam logic [3:0] StEmit  = 4'd6;

  logic [3:0]  state_r;
  logic [5:0]  fill_r;
  logic [63:0] total_r;
  logic        final_r;     // request ends the message
  logic        second_r;    // one more padded block follows
  logic [6:0]  cnt_r;
  word_t       h_r [8];
  word_t       s_r [8];
  word_t       w_r [16];
  word_t       acc_r;
  logic [7:0]  pad_len_r;   // padding pass counter for zero fill
  logic [2:0]  oidx_r;

  logic        ram_we;
  logic [5:0]  ram_wa, ram_ra;
  logic [7:0]  ram_wd, ram_rd;

  sha_ram #(.Width(8), .Depth(BlockBytes)) u_block (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  logic acc_in;
  assign in_stall = (state_r != StIdle);
  assign acc_in   = in_valid && !in_stall;

  // round logic
  word_t t1, t2, wnew, wcur;
  logic [5:0] rnd;
  assign rnd = cnt_r[5:0];
  always_comb begin
    wcur = w_r[0];
    wnew = (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10)) + w_r[9] +
           (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[0];
    t1 = s_r[7] + (rotr(s_r[4], 6) ^ rotr(s_r[4], 11) ^ rotr(s_r[4], 25)) +
         ((s_r[4] & s_r[5]) ^ (~s_r[4] & s_r[6])) + round_k(rnd) + wcur;
    t2 = (rotr(s_r[0], 2) ^ rotr(s_r[0], 13) ^ rotr(s_r[0], 22)) +
         ((s_r[0] & s_r[1]) ^ (s_r[0] & s_r[2]) ^ (s_r[1] & s_r[2]));
  end

  // length byte for padding position 56..63
  logic [63:0] bits;
  logic [2:0]  lpos;
  assign bits = {total_r[60:0], 3'b000};
  assign lpos = cnt_r[2:0];

  // block RAM port control
  always_comb begin
    ram_we = 1'b0;
    ram_wa = fill_r;
    ram_wd = in_msg_byte;
    ram_ra = cnt_r[5:0];
    case (state_r)
      StIdle: begin
        ram_we = acc_in && in_has_byte;
      end
      StPad: begin
        ram_we = 1'b1;
        ram_wa = pad_len_r[5:0];
        // the length-only block carries no 0x80 marker
        ram_wd = (!second_r && pad_len_r[6:0] == {1'b0, fill_r}) ? 8'h80 : 8'h00;
      end
      StLen: begin
        ram_we = 1'b1;
        ram_wa = {3'b111, lpos};
        ram_wd = bits[63 - 8*lpos -: 8];
      end
      default: ;
    endcase
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= StIdle;
      fill_r    <= '0;
      total_r   <= '0;
      final_r   <= 1'b0;
      second_r  <= 1'b0;
      cnt_r     <= '0;
      pad_len_r <= '0;
      oidx_r    <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      case (state_r)
        StIdle: begin
          if (acc_in) begin
            final_r <= in_is_last;
            if (in_has_byte) begin
              total_r <= total_r + 64'd1;
              fill_r  <= fill_r + 6'd1;
            end
            if (in_has_byte && fill_r == 6'd63) begin
              state_r   <= StLoad;
              cnt_r     <= '0;
              pad_len_r <= '0;
            end else if (in_is_last) begin
              state_r   <= StPad;
              pad_len_r <= {2'b00, fill_r + 6'(in_has_byte)};
            end
          end
        end
        // write 0x80 (not in a length-only block) then zeros to byte 63
        StPad: begin
          pad_len_r <= pad_len_r + 8'd1;
          if (pad_len_r[5:0] == 6'd63) begin
            if (second_r || fill_r < 6'd56) begin
              state_r <= StLen;
              cnt_r   <= '0;
            end else begin
              state_r <= StLoad;
              cnt_r   <= '0;
            end
          end
        end
        StLen: begin
          cnt_r <= cnt_r + 7'd1;
          if (lpos == 3'd7) begin
            state_r  <= StLoad;
            cnt_r    <= '0;
            second_r <= 1'b0;
          end
        end
        // gather block words; byte read data is registered, so it trails its address
        StLoad: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r != 7'd0) begin
            acc_r <= {acc_r[23:0], ram_rd};
            if (cnt_r[1:0] == 2'b00) begin
              for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
              w_r[15] <= {acc_r[23:0], ram_rd};
            end
          end
          if (cnt_r == 7'd64) begin
            state_r <= StRound;
            cnt_r   <= '0;
            for (int i = 0; i < 8; i++) s_r[i] <= h_r[i];
          end
        end
        StRound: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          s_r[7] <= s_r[6]; s_r[6] <= s_r[5]; s_r[5] <= s_r[4];
          s_r[4] <= s_r[3] + t1;
          s_r[3] <= s_r[2]; s_r[2] <= s_r[1]; s_r[1] <= s_r[0];
          s_r[0] <= t1 + t2;
          cnt_r  <= cnt_r + 7'd1;
          if (rnd == 6'd63) state_r <= StFold;
        end
        StFold: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + s_r[i];
          cnt_r <= '0;
          if (!final_r) begin
            state_r <= StIdle;
          end else if (pad_len_r[6]) begin
            // padding already laid down: either length block pending or done
            if (second_r) begin
              state_r   <= StPad;
              pad_len_r <= 8'd0;
              fill_r    <= 6'd0;
            end else begin
              state_r <= StEmit;
              oidx_r  <= '0;
            end
          end else begin
            // a full block ended on the last request: pad a fresh block
            state_r   <= StPad;
            pad_len_r <= 8'd0;
            fill_r    <= 6'd0;
          end
        end
        StEmit: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              state_r <= StIdle;
              fill_r  <= '0;
              total_r <= '0;
              final_r <= 1'b0;
              for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
            end else begin
              for (int i = 0; i < 7; i++) h_r[i] <= h_r[i+1];
            end
          end
        end
        default: state_r <= StIdle;
      endcase
      // first pad pass with fill >= 56 needs a second length-only block
      if (state_r == StPad && pad_len_r[5:0] == 6'd63 && !second_r && fill_r >= 6'd56
          && pad_len_r[6:0] != 7'd0) begin
        second_r <= 1'b1;
      end
    end
  end

  assign out_valid       = (state_r == StEmit);
  assign out_digest_word = h_r[0];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

endmodule

// ===== hw/rtl/sha_ram.sv =====
module sha_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
